// ===== hw/rtl/hfua_pkg.sv =====
// Shared types and constants of the H.264 RTP FU-A packetiser.
package hfua_pkg;

  // Byte masks and flags of the FU indicator and FU header
  localparam logic [7:0] FU_A_TYPE    = 8'h1C;
  localparam logic [7:0] FU_START_BIT = 8'h80;
  localparam logic [7:0] FU_END_BIT   = 8'h40;
  localparam logic [7:0] NRI_MASK     = 8'hE0;
  localparam logic [7:0] TYPE_MASK    = 8'h1F;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  // Payload limit
  localparam logic [15:0] MIN_PAYLOAD       = 16'd4;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1388;

  // Register map: register index is paddr[2]
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  // Result buffer: up to three results per byte plus one still waiting
  localparam int unsigned GRP_MAX   = 3;
  localparam int unsigned RES_SLOTS = 4;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_end;
    logic [15:0] ts_inc;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/h264_rtp_fua_packetizer_unit.sv =====
// H.264 RTP packetiser: start-code removal, single-NAL packets and FU-A fragments.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   data_byte_i, buffer_length_i,
//                                                 timestamp_step_i
//   out      source     out_valid_o / out_stall_i out_byte_o, packet_end_o,
//                                                 timestamp_increment_o, last_of_item_o
//   cfg      APB slave  psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// Each byte is processed in the cycle it is accepted; its results are registered into the
// result buffer behind any result still waiting. One byte per cycle while each byte gives at
// most one result and the output is not stalled; a byte that opens an FU-A packet gives two or
// three, and the single output port drains them one per cycle, so the input stalls there.
// The input stalls while more than one result waits in the four-entry result buffer.
// Reset (rst_ni low, asynchronous) empties the buffer and restarts in the zero-skip phase.
module h264_rtp_fua_packetizer_unit #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input bytes
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic [23:0]                    buffer_length_i,
  input  logic [15:0]                    timestamp_step_i,
  // payload bytes
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           packet_end_o,
  output logic [15:0]                    timestamp_increment_o,
  output logic                           last_of_item_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hfua_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import hfua_pkg::*;

  localparam int unsigned LW = LENGTH_BITS;
  localparam int unsigned CW = ((LW > 16) ? LW : 16) + 1;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  // State
  phase_e        phase_q, phase_d;
  logic [LW-1:0] bytes_seen_q, bytes_seen_d;
  logic [LW-1:0] nal_rem_q, nal_rem_d;
  logic [15:0]   fill_q, fill_d;
  logic          frag_q, frag_d;
  logic [7:0]    fu_ind_q, fu_ind_d;
  logic [4:0]    nal_type_q, nal_type_d;
  logic [15:0]   max_payload_q;

  // Result buffer
  result_t       slot_q [RES_SLOTS];
  result_t       slot_d [RES_SLOTS];
  logic [2:0]    count_q, count_d;

  // Per-byte work
  logic          in_acc, pop;
  logic [15:0]   lim;
  logic [LW-1:0] blen;
  logic [LW:0]   seen_inc;
  logic          buf_last;
  logic [LW-1:0] hdr_len;
  logic          len_fits, len_one;
  logic          nal_end, last_frag, pend;
  logic [16:0]   fill_eff;
  logic [7:0]    ind_new;
  logic          cfg_wr;
  result_t       grp [GRP_MAX];
  logic [1:0]    grp_n;
  logic [2:0]    cnt_pop;

  // Handshakes
  assign in_stall_o  = (count_q > 3'd1);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != 3'd0);
  assign pop         = out_valid_o && !out_stall_i;

  assign out_byte_o            = slot_q[0].out_byte;
  assign packet_end_o          = slot_q[0].packet_end;
  assign timestamp_increment_o = slot_q[0].ts_inc;
  assign last_of_item_o        = slot_q[0].last;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);
  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {16'd0, max_payload_q} : 32'd0;

  // Lengths and limits
  assign lim       = (max_payload_q < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_q;
  assign blen      = LW'(buffer_length_i);
  assign seen_inc  = {1'b0, bytes_seen_q} + {{LW{1'b0}}, 1'b1};
  assign buf_last  = (seen_inc >= {1'b0, blen});
  assign hdr_len   = buf_last ? LW'(1) : (blen - bytes_seen_q);
  assign len_fits  = (CW'(hdr_len) <= CW'(lim));
  assign len_one   = (hdr_len == LW'(1));
  assign nal_end   = (nal_rem_q <= LW'(1));
  assign last_frag = (CW'(nal_rem_q) <= CW'(lim - 16'd2));
  assign fill_eff  = (fill_q == 16'd0) ? 17'd3 : ({1'b0, fill_q} + 17'd1);
  assign pend      = nal_end || (fill_eff >= {1'b0, lim});
  assign ind_new   = (data_byte_i & NRI_MASK) | FU_A_TYPE;

  // Next state and result group of the byte at the input
  always_comb begin
    phase_d      = phase_q;
    bytes_seen_d = bytes_seen_q;
    nal_rem_d    = nal_rem_q;
    fill_d       = fill_q;
    frag_d       = frag_q;
    fu_ind_d     = fu_ind_q;
    nal_type_d   = nal_type_q;
    grp_n        = 2'd0;
    for (int i = 0; i < GRP_MAX; i++) begin
      grp[i] = '0;
    end

    case (phase_q)
      PH_HEADER: begin
        bytes_seen_d = seen_inc[LW-1:0];
        fu_ind_d     = ind_new;
        nal_type_d   = data_byte_i[4:0];
        if (len_fits) begin
          frag_d     = 1'b0;
          grp[0]     = '{out_byte: data_byte_i, packet_end: len_one,
                         ts_inc: len_one ? timestamp_step_i : 16'd0, last: 1'b0};
          grp_n      = 2'd1;
          if (len_one) begin
            phase_d      = PH_SKIP;
            bytes_seen_d = '0;
            nal_rem_d    = '0;
            fill_d       = '0;
          end else begin
            nal_rem_d = hdr_len - LW'(1);
            phase_d   = PH_DATA;
          end
        end else begin
          frag_d    = 1'b1;
          grp[0]    = '{out_byte: ind_new, packet_end: 1'b0, ts_inc: 16'd0, last: 1'b0};
          grp[1]    = '{out_byte: (data_byte_i & TYPE_MASK) | FU_START_BIT,
                        packet_end: 1'b0, ts_inc: 16'd0, last: 1'b0};
          grp_n     = 2'd2;
          fill_d    = 16'd2;
          nal_rem_d = hdr_len - LW'(1);
          phase_d   = PH_DATA;
        end
      end
      PH_DATA: begin
        bytes_seen_d = seen_inc[LW-1:0];
        if (!frag_q) begin
          grp[0] = '{out_byte: data_byte_i, packet_end: nal_end,
                     ts_inc: nal_end ? timestamp_step_i : 16'd0, last: 1'b0};
          grp_n  = 2'd1;
        end else begin
          // open a new FU-A packet with indicator and header first
          if (fill_q == 16'd0) begin
            grp[0] = '{out_byte: fu_ind_q, packet_end: 1'b0, ts_inc: 16'd0, last: 1'b0};
            grp[1] = '{out_byte: {3'b000, nal_type_q} | (last_frag ? FU_END_BIT : ZERO_BYTE),
                       packet_end: 1'b0, ts_inc: 16'd0, last: 1'b0};
            grp[2] = '{out_byte: data_byte_i, packet_end: pend,
                       ts_inc: nal_end ? timestamp_step_i : 16'd0, last: 1'b0};
            grp_n  = 2'd3;
          end else begin
            grp[0] = '{out_byte: data_byte_i, packet_end: pend,
                       ts_inc: nal_end ? timestamp_step_i : 16'd0, last: 1'b0};
            grp_n  = 2'd1;
          end
          fill_d = pend ? 16'd0 : fill_eff[15:0];
        end
        if (nal_end) begin
          phase_d      = PH_SKIP;
          bytes_seen_d = '0;
          nal_rem_d    = '0;
          fill_d       = '0;
          frag_d       = 1'b0;
        end else begin
          nal_rem_d = nal_rem_q - LW'(1);
        end
      end
      default: begin
        // drop leading zeros and the start-code end
        bytes_seen_d = seen_inc[LW-1:0];
        if (data_byte_i != ZERO_BYTE) begin
          phase_d = PH_HEADER;
        end
        if (buf_last) begin
          phase_d      = PH_SKIP;
          bytes_seen_d = '0;
          nal_rem_d    = '0;
          fill_d       = '0;
          frag_d       = 1'b0;
        end
      end
    endcase

    // flag the last result of this byte
    for (int i = 0; i < GRP_MAX; i++) begin
      grp[i].last = (grp_n == 2'(i + 1));
    end
  end

  // Pop the head and append the new group behind what remains
  always_comb begin
    logic [2:0] k;
    cnt_pop = count_q - {2'b00, pop};
    count_d = in_acc ? (cnt_pop + {1'b0, grp_n}) : cnt_pop;
    for (int i = 0; i < RES_SLOTS; i++) begin
      if (pop && (i < RES_SLOTS - 1)) begin
        slot_d[i] = slot_q[(i + 1) % RES_SLOTS];
      end else begin
        slot_d[i] = slot_q[i];
      end
      k = 3'(i) - cnt_pop;
      if (in_acc && (3'(i) >= cnt_pop) && (k < {1'b0, grp_n})) begin
        slot_d[i] = grp[k[1:0]];
      end
    end
  end

  // Hold control state and the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SKIP;
      bytes_seen_q  <= '0;
      nal_rem_q     <= '0;
      fill_q        <= '0;
      frag_q        <= 1'b0;
      fu_ind_q      <= '0;
      nal_type_q    <= '0;
      max_payload_q <= MAX_PAYLOAD_RESET;
      count_q       <= '0;
    end else begin
      if (in_acc) begin
        phase_q      <= phase_d;
        bytes_seen_q <= bytes_seen_d;
        nal_rem_q    <= nal_rem_d;
        fill_q       <= fill_d;
        frag_q       <= frag_d;
        fu_ind_q     <= fu_ind_d;
        nal_type_q   <= nal_type_d;
      end
      if (cfg_wr) begin
        max_payload_q <= pwdata[15:0];
      end
      count_q <= count_d;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_SLOTS; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

// ===== hw/rtl/hfua_checker.sv =====
// Port-level checks of the FU-A packetiser, bound to its top level.
module hfua_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [7:0]                   out_byte_o,
  input logic                         packet_end_o,
  input logic [15:0]                  timestamp_increment_o,
  input logic                         last_of_item_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [hfua_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready
);
  import hfua_pkg::*;

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(packet_end_o) && $stable(timestamp_increment_o) && $stable(last_of_item_o))
    else $error("stalled output transaction changed");

  // Increment only on a packet's final byte
  a_inc_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !packet_end_o |-> timestamp_increment_o == 16'd0)
    else $error("timestamp increment outside packet end");

  // Input stalls only with results waiting
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // Read back the payload limit just written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == REG_MAX_PAYLOAD) |=>
      (paddr[2] != REG_MAX_PAYLOAD) ||
      (prdata == {16'd0, $past(pwdata[15:0])}))
    else $error("payload limit read-back mismatch");

endmodule

bind h264_rtp_fua_packetizer_unit hfua_checker u_hfua_checker (.*);
